/* rtl/dttl_pkg.sv */
// Shared types, constants and helpers for the zone-file TTL parser.
`timescale 1ns / 1ps

package dttl_pkg;

    // Default limit on characters consumed by one field.
    localparam int MAX_FIELD_CHARS_DEF = 255;

    // Queue depths between the front, the back and the result port.
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int RES_FIFO_DEPTH = 2;

    // Unit multipliers in seconds; a week fits in 20 bits.
    localparam int SCALE_W = 20;
    localparam logic [SCALE_W-1:0] SEC_PER_WEEK   = 20'd604800;
    localparam logic [SCALE_W-1:0] SEC_PER_DAY    = 20'd86400;
    localparam logic [SCALE_W-1:0] SEC_PER_HOUR   = 20'd3600;
    localparam logic [SCALE_W-1:0] SEC_PER_MINUTE = 20'd60;
    localparam logic [SCALE_W-1:0] SEC_PER_SECOND = 20'd1;

    // ASCII codes the front recognizes.
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_CASE_BIT = 8'h20;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_W      = 8'h77;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_S      = 8'h73;

    // One input item: a character and the end-of-text flag.
    typedef struct packed {
        logic [7:0] char_code;
        logic       field_end;
    } t_char_item;

    // One result item.
    typedef struct packed {
        logic [31:0] ttl_seconds;
        logic        bad_ttl;
        logic [7:0]  chars_used;
    } t_ttl_item;

    // Character classes produced by the front.
    typedef enum logic [1:0] {
        CLS_DIGIT,
        CLS_TERM,
        CLS_UNIT,
        CLS_ILLEGAL
    } t_char_class;

    // Unit letters.
    typedef enum logic [2:0] {
        UNIT_WEEK,
        UNIT_DAY,
        UNIT_HOUR,
        UNIT_MINUTE,
        UNIT_SECOND
    } t_unit;

    // Classified character handed from the front to the back.
    typedef struct packed {
        t_char_class cls;
        logic [3:0]  digit;
        t_unit       unit;
        logic        field_end;
    } t_cmd;

    // Seconds per unit letter.
    function automatic logic [SCALE_W-1:0] unit_scale(input t_unit u);
        logic [SCALE_W-1:0] s;
        case (u)
            UNIT_WEEK:   s = SEC_PER_WEEK;
            UNIT_DAY:    s = SEC_PER_DAY;
            UNIT_HOUR:   s = SEC_PER_HOUR;
            UNIT_MINUTE: s = SEC_PER_MINUTE;
            UNIT_SECOND: s = SEC_PER_SECOND;
            default:     s = SEC_PER_SECOND;
        endcase
        return s;
    endfunction

endpackage

/* rtl/dttl_fifo.sv */
// Small register-based first-in first-out queue used between the parser stages.
`timescale 1ns / 1ps

module dttl_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    // Pointer and occupancy update; pointers wrap at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/dttl_front.sv */
// Front stage: accepts characters and classifies them for the back stage.
`timescale 1ns / 1ps

module dttl_front (
    input  logic                  i_push,
    input  dttl_pkg::t_char_item  i_char_item,
    input  logic                  i_cmd_full,
    output logic                  o_cmd_push,
    output dttl_pkg::t_cmd        o_cmd
);

    logic [7:0] lower;
    logic [7:0] code;

    assign code = i_char_item.char_code;

    // An item moves on whenever the command queue has room.
    assign o_cmd_push = i_push && !i_cmd_full;

    // Fold upper-case letters so unit letters match in either case.
    assign lower = (code >= dttl_pkg::CH_UPPER_A && code <= dttl_pkg::CH_UPPER_Z)
                 ? (code | dttl_pkg::CH_CASE_BIT) : code;

    // Classify the character.
    always_comb begin
        o_cmd.cls       = dttl_pkg::CLS_ILLEGAL;
        o_cmd.digit     = code[3:0];
        o_cmd.unit      = dttl_pkg::UNIT_SECOND;
        o_cmd.field_end = i_char_item.field_end;
        if (code >= dttl_pkg::CH_ZERO && code <= dttl_pkg::CH_NINE) begin
            o_cmd.cls = dttl_pkg::CLS_DIGIT;
        end else begin
            case (lower)
                dttl_pkg::CH_SPACE, dttl_pkg::CH_TAB, dttl_pkg::CH_LPAREN,
                dttl_pkg::CH_RPAREN, dttl_pkg::CH_CR, dttl_pkg::CH_LF,
                dttl_pkg::CH_SEMI: begin
                    o_cmd.cls = dttl_pkg::CLS_TERM;
                end
                dttl_pkg::CH_W: begin
                    o_cmd.cls  = dttl_pkg::CLS_UNIT;
                    o_cmd.unit = dttl_pkg::UNIT_WEEK;
                end
                dttl_pkg::CH_D: begin
                    o_cmd.cls  = dttl_pkg::CLS_UNIT;
                    o_cmd.unit = dttl_pkg::UNIT_DAY;
                end
                dttl_pkg::CH_H: begin
                    o_cmd.cls  = dttl_pkg::CLS_UNIT;
                    o_cmd.unit = dttl_pkg::UNIT_HOUR;
                end
                dttl_pkg::CH_M: begin
                    o_cmd.cls  = dttl_pkg::CLS_UNIT;
                    o_cmd.unit = dttl_pkg::UNIT_MINUTE;
                end
                dttl_pkg::CH_S: begin
                    o_cmd.cls  = dttl_pkg::CLS_UNIT;
                    o_cmd.unit = dttl_pkg::UNIT_SECOND;
                end
                default: begin
                    o_cmd.cls = dttl_pkg::CLS_ILLEGAL;
                end
            endcase
        end
    end

endmodule

/* rtl/dttl_back.sv */
// Back stage: runs the field state machine and produces one result per field.
`timescale 1ns / 1ps

module dttl_back #(
    parameter int MAX_FIELD_CHARS = dttl_pkg::MAX_FIELD_CHARS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dttl_pkg::t_cmd       i_cmd,
    input  logic                 i_cmd_empty,
    output logic                 o_cmd_pop,
    input  logic                 i_res_full,
    output logic                 o_res_push,
    output dttl_pkg::t_ttl_item  o_res
);

    localparam int CW = $clog2(MAX_FIELD_CHARS + 1);
    localparam int WW = (CW > 8) ? CW : 8;
    localparam int SW = dttl_pkg::SCALE_W;
    localparam int PW = 32 + SW;

    typedef enum logic [1:0] {
        PH_START,
        PH_NUM,
        PH_UNIT
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [31:0]     r_pend, n_pend;
    logic [31:0]     r_total, n_total;
    logic [CW-1:0]   r_count, n_count;

    logic            fire;
    logic            end_c;
    logic            grp_end;
    logic [CW-1:0]   cnt_inc;
    logic [CW-1:0]   cnt_grp;
    logic [35:0]     dig_val;
    logic [SW-1:0]   scale;
    logic [PW-1:0]   prod;
    logic [PW:0]     sum;
    logic            fin;
    logic            fin_bad;
    logic [31:0]     fin_ttl;
    logic [CW-1:0]   fin_cnt;
    logic [WW-1:0]   fin_cnt_w;

    // A command is taken whenever one is waiting and a result slot is free.
    assign fire      = !i_cmd_empty && !i_res_full;
    assign o_cmd_pop = fire;

    // Text end, or the length limit reached, acts as a terminator.
    assign end_c   = i_cmd.field_end || (r_count >= CW'(MAX_FIELD_CHARS));
    assign cnt_inc = (r_count < CW'(MAX_FIELD_CHARS)) ? r_count + CW'(1) : r_count;
    assign grp_end = end_c || (i_cmd.cls == dttl_pkg::CLS_TERM);
    assign cnt_grp = grp_end ? r_count : cnt_inc;

    // Decimal accumulate and group scale-and-add.
    assign dig_val = 36'(r_pend) * 36'd10 + 36'(i_cmd.digit);
    assign scale   = grp_end ? dttl_pkg::SEC_PER_SECOND : dttl_pkg::unit_scale(i_cmd.unit);
    assign prod    = PW'(r_pend) * PW'(scale);
    assign sum     = (PW + 1)'(prod) + (PW + 1)'(r_total);

    // Next-state logic of the field parser.
    always_comb begin
        n_phase = r_phase;
        n_pend  = r_pend;
        n_total = r_total;
        n_count = r_count;
        fin     = 1'b0;
        fin_bad = 1'b0;
        fin_ttl = '0;
        fin_cnt = r_count;
        if (fire) begin
            case (r_phase)
                PH_NUM: begin
                    if (!end_c && i_cmd.cls == dttl_pkg::CLS_DIGIT) begin
                        if (dig_val[35:32] != 4'd0) begin
                            fin     = 1'b1;
                            fin_bad = 1'b1;
                        end else begin
                            n_pend  = dig_val[31:0];
                            n_count = cnt_inc;
                        end
                    end else if (!end_c && i_cmd.cls == dttl_pkg::CLS_ILLEGAL) begin
                        fin     = 1'b1;
                        fin_bad = 1'b1;
                    end else if (sum[PW:32] != '0) begin
                        // Total overflow; the unit letter still counts.
                        fin     = 1'b1;
                        fin_bad = 1'b1;
                        fin_cnt = cnt_grp;
                    end else if (grp_end) begin
                        fin     = 1'b1;
                        fin_ttl = sum[31:0];
                    end else begin
                        n_total = sum[31:0];
                        n_pend  = '0;
                        n_count = cnt_inc;
                        n_phase = PH_UNIT;
                    end
                end
                default: begin
                    if (!end_c && i_cmd.cls == dttl_pkg::CLS_DIGIT) begin
                        n_pend  = 32'(i_cmd.digit);
                        n_count = cnt_inc;
                        n_phase = PH_NUM;
                    end else begin
                        fin     = 1'b1;
                        fin_ttl = (r_phase == PH_UNIT) ? r_total : 32'd0;
                    end
                end
            endcase
            if (fin) begin
                n_phase = PH_START;
                n_pend  = '0;
                n_total = '0;
                n_count = '0;
            end
        end
    end

    // Result item, with the character count saturated to eight bits.
    assign fin_cnt_w             = WW'(fin_cnt);
    assign o_res_push            = fin;
    assign o_res.ttl_seconds     = fin_ttl;
    assign o_res.bad_ttl         = fin_bad;
    assign o_res.chars_used      = (fin_cnt_w > WW'(255)) ? 8'hFF : fin_cnt_w[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_pend  <= '0;
            r_total <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_total <= n_total;
            r_count <= n_count;
        end
    end

    // A field starts clean after reset.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == PH_START && r_count == '0 && r_total == '0))
        else $error("parser state not cleared by reset");

    // No completed group is carried while waiting for a field to start.
    a_start_no_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_START) |-> (r_total == '0))
        else $error("running total left over at start of field");

    // Every result returns the parser to the start of a field.
    a_result_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> (r_phase == PH_START && r_pend == '0))
        else $error("parser did not restart after a result");

    // A flagged result carries no TTL.
    a_bad_zero_ttl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.bad_ttl) |-> (o_res.ttl_seconds == 32'd0))
        else $error("bad TTL result with nonzero value");

    // The consumed count never passes the field limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FIELD_CHARS))
        else $error("character count beyond field limit");

endmodule

/* rtl/dns_ttl_unit_parser_core.sv */
// Path: a character item waits in the command queue for the back stage, and the result
// of the field it ends is written into the result queue, from which it can be popped.
// Throughput: one character item per cycle while no queue is full, set by the back stage's
// combinational scale-and-add (one constant multiply, one add and an overflow compare).
// A two-entry command queue and a two-entry result queue let either side stall on its own.
// Reset: synchronous, active low; clears both queues and the field state.
`timescale 1ns / 1ps

module dns_ttl_unit_parser_core #(
    parameter int MAX_FIELD_CHARS = dttl_pkg::MAX_FIELD_CHARS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  dttl_pkg::t_char_item i_char_item,
    output logic                 empty,
    input  logic                 pop,
    output dttl_pkg::t_ttl_item  o_ttl_item
);

    localparam int CMD_W = $bits(dttl_pkg::t_cmd);
    localparam int RES_W = $bits(dttl_pkg::t_ttl_item);

    logic                 cmd_push;
    logic                 cmd_pop;
    logic                 cmd_empty;
    dttl_pkg::t_cmd       cmd_in;
    dttl_pkg::t_cmd       cmd_out;
    logic [CMD_W-1:0]     cmd_out_bits;
    logic                 res_push;
    logic                 res_full;
    dttl_pkg::t_ttl_item  res_in;
    logic [RES_W-1:0]     res_out_bits;

    // Character classification.
    dttl_front u_front (
        .i_push      (push),
        .i_char_item (i_char_item),
        .i_cmd_full  (full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    // Queue between front and back.
    dttl_fifo #(
        .DATA_W (CMD_W),
        .DEPTH  (dttl_pkg::CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out_bits),
        .o_empty (cmd_empty)
    );

    assign cmd_out = dttl_pkg::t_cmd'(cmd_out_bits);

    // Field state machine.
    dttl_back #(
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Result queue facing the consumer.
    dttl_fifo #(
        .DATA_W (RES_W),
        .DEPTH  (dttl_pkg::RES_FIFO_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out_bits),
        .o_empty (empty)
    );

    assign o_ttl_item = dttl_pkg::t_ttl_item'(res_out_bits);

endmodule
